### rtl/dlz_pkg.sv
// Shared constants for the dword LZ stream decompressor.
package dlz_pkg;

  localparam int WORD_W           = 32;
  localparam int HISTORY_DWORDS_D = 65536;
  localparam int MAX_MATCH_D      = 127;

  // Tag layout
  localparam int DIST_W    = 16;
  localparam int MLEN_W    = 7;
  localparam int MLEN_LSB  = 16;
  localparam int RLEN_LSB  = 23;
  localparam int BOFF_LSB  = 30;
  localparam int BOFF_W    = 2;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'hFFFF_0000;

  // Width for signed history offset and distance compares
  localparam int CMP_W     = 18;
  // Dwords caused by one input word: one raw plus a full match
  localparam int CNT_W     = 8;

endpackage

### rtl/dlz_if.sv
// Stream channel interfaces for compressed input and decoded output words.
interface dlz_in_if
  import dlz_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] in_word;
  logic              in_last;

  modport source (output valid, in_word, in_last, input ready);
  modport sink   (input valid, in_word, in_last, output ready);
endinterface

interface dlz_out_if
  import dlz_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word0;
  logic [WORD_W-1:0] out_word1;
  logic [1:0]        out_count;
  logic              stream_end;
  logic              bad_distance;
  logic              last;

  modport source (output valid, out_word0, out_word1, out_count, stream_end, bad_distance,
                  last, input ready);
  modport sink   (input valid, out_word0, out_word1, out_count, stream_end, bad_distance,
                  last, output ready);
endinterface

### rtl/dword_lz_stream_decompressor.sv
// Dword LZ77 stream decompressor: tag parser, history memory and match copier.
//
// One compressed word is taken while the block is idle. A raw word is accepted,
// then written to history; every match dword then takes a history read issue,
// then assembly and write back, and a write stalls while the output register is
// full and a result must leave. A word that decodes to nothing returns to idle at
// once, and one that only ends the stream emits an empty end result. The history
// read ports are registered, so each match dword is written back before the next
// one reads. Decoded dwords leave in pairs through an output register, the last
// of an item alone if odd; one dword is held back while a result waits. There is
// no clearing pass: history entries are only read once written, and distances
// beyond the written count read as zero.
module dword_lz_stream_decompressor
  import dlz_pkg::*;
#(
  parameter int HISTORY_DWORDS   = HISTORY_DWORDS_D,
  parameter int MAX_MATCH_DWORDS = MAX_MATCH_D
) (
  input  logic       clk,
  input  logic       rst,
  dlz_in_if.sink     in_ch,
  dlz_out_if.source  out_ch
);

  localparam int AW   = $clog2(HISTORY_DWORDS);
  localparam int WW_W = $clog2(HISTORY_DWORDS + 1);

  typedef enum logic [1:0] {M_TAG, M_RAW, M_DONE} pmode_t;
  typedef enum logic [2:0] {S_IDLE, S_RAWW, S_MRD, S_MWR, S_EMPTY} state_t;

  state_t               st;
  pmode_t               pmode;
  logic [DIST_W-1:0]    raw_left;
  logic [MLEN_W-1:0]    pend_len;
  logic [DIST_W-1:0]    pend_dd;
  logic [BOFF_W-1:0]    pend_boff;
  logic [AW-1:0]        head;
  logic [WW_W-1:0]      ww;
  logic [WORD_W-1:0]    raw_w;
  logic [DIST_W-1:0]    m_dd;
  logic [BOFF_W-1:0]    m_boff;
  logic [CNT_W-1:0]     words_left;
  logic                 lastin_r;
  logic                 endf_r;
  logic                 bad_r;
  logic [WORD_W-1:0]    pair0;
  logic                 has;
  logic                 ovalid;
  logic [WORD_W-1:0]    o_w0;
  logic [WORD_W-1:0]    o_w1;
  logic [1:0]           o_cnt;
  logic                 o_end;
  logic                 o_bad;
  logic                 o_last;

  logic [WORD_W-1:0]    mem [HISTORY_DWORDS];
  logic [WORD_W-1:0]    rd_a;
  logic [WORD_W-1:0]    rd_b;

  // Accept-time decode results
  pmode_t               pmode_next;
  logic [DIST_W-1:0]    raw_left_next;
  logic [MLEN_W-1:0]    pend_len_next;
  logic [DIST_W-1:0]    pend_dd_next;
  logic [BOFF_W-1:0]    pend_boff_next;
  logic                 do_raw;
  logic                 do_match;
  logic [MLEN_W-1:0]    mlen;
  logic [DIST_W-1:0]    mdd;
  logic [BOFF_W-1:0]    mboff;
  logic                 endf;
  logic [WW_W-1:0]      ww_after;
  logic                 bad;
  logic [CNT_W-1:0]     total;

  logic [MLEN_W-1:0]    t_ml;
  logic [MLEN_W-1:0]    t_rl;
  logic [DIST_W-1:0]    rl_dec;

  logic                 accept;
  logic                 slot_free;
  logic                 final_w;
  logic                 emit;
  logic                 push_ok;
  logic                 load_out;
  logic [WORD_W-1:0]    push_w;
  logic [WORD_W-1:0]    match_w;
  logic [CMP_W-1:0]     diff_a;
  logic [CMP_W-1:0]     diff_b;
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st == S_IDLE);
  assign slot_free = !ovalid || out_ch.ready;

  assign t_ml   = in_ch.in_word[MLEN_LSB +: MLEN_W];
  assign t_rl   = in_ch.in_word[RLEN_LSB +: MLEN_W];
  assign rl_dec = (raw_left != '0) ? raw_left - 1'b1 : raw_left;

  // Decode the incoming word against the parse state
  always_comb begin
    pmode_next     = pmode;
    raw_left_next  = raw_left;
    pend_len_next  = pend_len;
    pend_dd_next   = pend_dd;
    pend_boff_next = pend_boff;
    do_raw         = 1'b0;
    do_match       = 1'b0;
    mlen           = pend_len;
    mdd            = pend_dd;
    mboff          = pend_boff;
    endf           = 1'b0;
    case (pmode)
      M_RAW: begin
        do_raw        = 1'b1;
        raw_left_next = rl_dec;
        if (rl_dec == '0) begin
          do_match      = (pend_len != '0);
          pend_len_next = '0;
          pmode_next    = M_TAG;
        end
      end
      M_TAG: begin
        mlen  = t_ml;
        mdd   = in_ch.in_word[DIST_W-1:0];
        mboff = in_ch.in_word[BOFF_LSB +: BOFF_W];
        if (t_ml != '0) begin
          if (t_rl != '0) begin
            raw_left_next  = DIST_W'(t_rl);
            pend_len_next  = t_ml;
            pend_dd_next   = in_ch.in_word[DIST_W-1:0];
            pend_boff_next = in_ch.in_word[BOFF_LSB +: BOFF_W];
            pmode_next     = M_RAW;
          end else begin
            do_match = 1'b1;
          end
        end else if (in_ch.in_word == '0) begin
          endf       = 1'b1;
          pmode_next = M_DONE;
        end else if ((in_ch.in_word & UPPER_MASK) == '0) begin
          raw_left_next = in_ch.in_word[DIST_W-1:0];
          pend_len_next = '0;
          pmode_next    = M_RAW;
        end
      end
      default: begin
      end
    endcase
    if (in_ch.in_last) begin
      endf           = 1'b1;
      pmode_next     = M_TAG;
      raw_left_next  = '0;
      pend_len_next  = '0;
      pend_dd_next   = '0;
      pend_boff_next = '0;
    end
    if (32'(mlen) > MAX_MATCH_DWORDS) begin
      mlen = MLEN_W'(MAX_MATCH_DWORDS);
    end
  end

  // Flag a zero distance or a match reaching before stream start, count the dwords the word makes
  always_comb begin
    ww_after = ww;
    if (do_raw && (ww != WW_W'(HISTORY_DWORDS))) begin
      ww_after = ww + 1'b1;
    end
    bad   = do_match && ((mdd == '0) || (CMP_W'(mdd) > CMP_W'(ww_after)));
    total = CNT_W'(do_raw) + (do_match ? CNT_W'(mlen) : '0);
  end

  // Form the history addresses of the two source dwords
  always_comb begin
    diff_a = CMP_W'(head) - CMP_W'(m_dd);
    if (diff_a[CMP_W-1]) begin
      diff_a = diff_a + CMP_W'(HISTORY_DWORDS);
    end
    diff_b = CMP_W'(head) - CMP_W'(m_dd) + 1'b1;
    if (diff_b[CMP_W-1]) begin
      diff_b = diff_b + CMP_W'(HISTORY_DWORDS);
    end
    addr_a = diff_a[AW-1:0];
    addr_b = diff_b[AW-1:0];
  end

  // Assemble one match dword byte by byte; a one-dword distance feeds on itself
  always_comb begin
    logic [WORD_W-1:0] src_a;
    logic [WORD_W-1:0] src_b;
    logic [2:0]        sb;
    logic [1:0]        k;
    src_a = (CMP_W'(m_dd) <= CMP_W'(ww)) ? rd_a : '0;
    src_b = (CMP_W'(m_dd) <= CMP_W'(ww) + 1'b1) ? rd_b : '0;
    match_w = '0;
    for (int b = 0; b < 4; b++) begin
      sb = 3'(b) + 3'(m_boff);
      k  = sb[1:0];
      if (!sb[2]) begin
        match_w[8*b +: 8] = src_a[8*k +: 8];
      end else if (m_dd == DIST_W'(1)) begin
        match_w[8*b +: 8] = match_w[8*k +: 8];
      end else begin
        match_w[8*b +: 8] = src_b[8*k +: 8];
      end
    end
    if (m_dd == '0) begin
      match_w = '0;
    end
  end

  assign final_w  = (words_left == CNT_W'(1));
  assign emit     = has || final_w;
  assign push_ok  = !emit || slot_free;
  assign push_w   = (st == S_RAWW) ? raw_w : match_w;
  assign load_out = (((st == S_RAWW) || (st == S_MWR)) && push_ok && emit)
                 || ((st == S_EMPTY) && slot_free);

  // History memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (((st == S_RAWW) || (st == S_MWR)) && push_ok) begin
      mem[head] <= push_w;
    end
    if (st == S_MRD) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Sequencer, parse state, pairing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      pmode      <= M_TAG;
      raw_left   <= '0;
      pend_len   <= '0;
      pend_dd    <= '0;
      pend_boff  <= '0;
      head       <= '0;
      ww         <= '0;
      words_left <= '0;
      has        <= 1'b0;
      ovalid     <= 1'b0;
      lastin_r   <= 1'b0;
      endf_r     <= 1'b0;
      bad_r      <= 1'b0;
    end else begin
      // load a new result, or drop the one taken
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            pmode      <= pmode_next;
            raw_left   <= raw_left_next;
            pend_len   <= pend_len_next;
            pend_dd    <= pend_dd_next;
            pend_boff  <= pend_boff_next;
            raw_w      <= in_ch.in_word;
            m_dd       <= mdd;
            m_boff     <= mboff;
            words_left <= total;
            lastin_r   <= in_ch.in_last;
            endf_r     <= endf;
            bad_r      <= bad;
            has        <= 1'b0;
            if (total == '0) begin
              if (endf) begin
                st <= S_EMPTY;
              end else if (in_ch.in_last) begin
                head <= '0;
                ww   <= '0;
              end
            end else if (do_raw) begin
              st <= S_RAWW;
            end else begin
              st <= S_MRD;
            end
          end
        end
        S_MRD: begin
          st <= S_MWR;
        end
        S_RAWW, S_MWR: begin
          if (push_ok) begin
            // advance the history write point, or restart it after the last word
            if (final_w && lastin_r) begin
              head <= '0;
              ww   <= '0;
            end else begin
              head <= (head == AW'(HISTORY_DWORDS - 1)) ? '0 : head + 1'b1;
              if (ww != WW_W'(HISTORY_DWORDS)) begin
                ww <= ww + 1'b1;
              end
            end
            words_left <= words_left - 1'b1;
            if (emit) begin
              o_w0   <= has ? pair0 : push_w;
              o_w1   <= has ? push_w : '0;
              o_cnt  <= has ? 2'd2 : 2'd1;
              o_end  <= final_w && endf_r;
              o_bad  <= bad_r;
              o_last <= final_w;
              has    <= 1'b0;
            end else begin
              pair0 <= push_w;
              has   <= 1'b1;
            end
            if (final_w) begin
              st <= S_IDLE;
            end else begin
              st <= S_MRD;
            end
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            o_w0   <= '0;
            o_w1   <= '0;
            o_cnt  <= 2'd0;
            o_end  <= 1'b1;
            o_bad  <= bad_r;
            o_last <= 1'b1;
            st     <= S_IDLE;
            if (lastin_r) begin
              head <= '0;
              ww   <= '0;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = ovalid;
  assign out_ch.out_word0    = o_w0;
  assign out_ch.out_word1    = o_w1;
  assign out_ch.out_count    = o_cnt;
  assign out_ch.stream_end   = o_end;
  assign out_ch.bad_distance = o_bad;
  assign out_ch.last         = o_last;

endmodule
